// ===== src/tte_pkg.sv =====
`timescale 1ns / 1ps

package tte_pkg;

    localparam logic [1:0] KIND_STORE = 2'd0;
    localparam logic [1:0] KIND_PROBE = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;

    localparam logic [1:0] BOUND_EXACT = 2'd1;
    localparam logic [1:0] BOUND_UPPER = 2'd2;
    localparam logic [1:0] BOUND_LOWER = 2'd3;

    localparam logic [1:0] OUTCOME_KEPT   = 2'd0;
    localparam logic [1:0] OUTCOME_FILL   = 2'd1;
    localparam logic [1:0] OUTCOME_DEEPER = 2'd2;
    localparam logic [1:0] OUTCOME_AGE    = 2'd3;

    typedef struct packed {
        logic [1:0]         kind;
        logic [63:0]        hash_key;
        logic [15:0]        best_move;
        logic signed [15:0] score;
        logic [1:0]         bound_kind;
        logic [7:0]         depth;
        logic [7:0]         search_age;
        logic signed [15:0] alpha;
        logic signed [15:0] beta;
    } t_req;

    typedef struct packed {
        logic               usable;
        logic               found;
        logic signed [15:0] out_score;
        logic [15:0]        out_move;
        logic [1:0]         out_bound;
        logic [7:0]         out_depth;
        logic [7:0]         out_age;
        logic [1:0]         store_outcome;
    } t_rsp;

    typedef struct packed {
        logic [63:0]        key;
        logic [15:0]        move;
        logic signed [15:0] score;
        logic [1:0]         bound;
        logic [7:0]         depth;
        logic [7:0]         age;
    } t_entry;

    typedef struct packed {
        logic clr_en;
        logic load;
        logic rd_en;
        logic exec;
    } t_ctl;

    typedef struct packed {
        logic clr_last;
    } t_sts;

endpackage

// ===== src/tte_ctrl.sv =====
`timescale 1ns / 1ps

module tte_ctrl
    import tte_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_sts i_sts,
    output t_ctl o_ctl
);

    typedef enum logic [1:0] {
        S_CLEAR,
        S_IDLE,
        S_READ,
        S_EXEC
    } t_state;

    t_state r_state;
    logic   r_busy;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
            r_busy  <= 1'b1;
        end else begin
            case (r_state)
                S_CLEAR: begin
                    if (i_sts.clr_last) begin
                        r_state <= S_IDLE;
                        r_busy  <= 1'b0;
                    end
                end
                S_IDLE: begin
                    if (start) begin
                        r_state <= S_READ;
                        r_busy  <= 1'b1;
                    end
                end
                S_READ: begin
                    r_state <= S_EXEC;
                end
                S_EXEC: begin
                    r_state <= S_IDLE;
                    r_busy  <= 1'b0;
                end
                default: begin
                    r_state <= S_CLEAR;
                    r_busy  <= 1'b1;
                end
            endcase
        end
    end

    assign busy  = r_busy;
    assign o_ctl = '{clr_en: (r_state == S_CLEAR),
                     load:   (r_state == S_IDLE) && start,
                     rd_en:  (r_state == S_READ),
                     exec:   (r_state == S_EXEC)};

endmodule

// ===== src/tte_dp.sv =====
`timescale 1ns / 1ps

module tte_dp
    import tte_pkg::*;
#(
    parameter int INDEX_BITS = 16
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  t_ctl i_ctl,
    output t_sts o_sts,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    localparam int DEPTH = 1 << INDEX_BITS;

    t_entry                  r_mem [DEPTH];
    t_req                    r_req;
    t_entry                  r_rdata;
    t_rsp                    r_rsp;
    logic                    r_valid;
    logic [INDEX_BITS-1:0]   r_clr_addr;

    logic [INDEX_BITS-1:0]   slot;
    t_rsp                    n_rsp;
    t_entry                  new_entry;
    logic                    hit;
    logic                    ok;
    logic                    wr_en;

    assign slot = r_req.hash_key[INDEX_BITS-1:0];
    assign hit  = (r_rdata.key == r_req.hash_key);
    assign o_sts.clr_last = (r_clr_addr == {INDEX_BITS{1'b1}});

    always_comb begin
        new_entry.key   = r_req.hash_key;
        new_entry.move  = r_req.best_move;
        new_entry.score = r_req.score;
        new_entry.bound = r_req.bound_kind;
        new_entry.depth = r_req.depth;
        new_entry.age   = r_req.search_age;

        n_rsp = '0;
        ok    = 1'b0;
        wr_en = 1'b0;
        case (r_req.kind)
            KIND_STORE: begin
                if (r_rdata.key == 64'd0) begin
                    n_rsp.store_outcome = OUTCOME_FILL;
                end else if (r_rdata.depth < r_req.depth) begin
                    n_rsp.store_outcome = OUTCOME_DEEPER;
                end else if (r_rdata.age != r_req.search_age) begin
                    n_rsp.store_outcome = OUTCOME_AGE;
                end else begin
                    n_rsp.store_outcome = OUTCOME_KEPT;
                end
                wr_en = (n_rsp.store_outcome != OUTCOME_KEPT);
            end
            KIND_PROBE, KIND_READ: begin
                if (hit) begin
                    n_rsp.found     = 1'b1;
                    n_rsp.out_move  = r_rdata.move;
                    n_rsp.out_bound = r_rdata.bound;
                    n_rsp.out_depth = r_rdata.depth;
                    n_rsp.out_age   = r_rdata.age;
                    if (r_req.kind == KIND_READ) begin
                        n_rsp.out_score = r_rdata.score;
                    end else begin
                        if (r_rdata.key != 64'd0 && r_rdata.depth >= r_req.depth) begin
                            ok = (r_rdata.bound == BOUND_EXACT)
                              || (r_rdata.bound == BOUND_UPPER
                                  && $signed(r_rdata.score) <= $signed(r_req.alpha))
                              || (r_rdata.bound == BOUND_LOWER
                                  && $signed(r_rdata.score) >= $signed(r_req.beta));
                        end
                        if (ok) begin
                            n_rsp.usable    = 1'b1;
                            n_rsp.out_score = r_rdata.score;
                        end
                    end
                end
            end
            default: begin
                n_rsp = '0;
            end
        endcase
    end

    // single write port: clear sweep or store update
    always_ff @(posedge i_clk) begin
        if (i_ctl.clr_en) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_ctl.exec && wr_en) begin
            r_mem[slot] <= new_entry;
        end
        if (i_ctl.rd_en) begin
            r_rdata <= r_mem[slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.load) begin
            r_req <= i_req;
        end
        if (i_ctl.exec) begin
            r_rsp <= n_rsp;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid    <= 1'b0;
            r_clr_addr <= '0;
        end else begin
            r_valid <= i_ctl.exec;
            if (i_ctl.clr_en) begin
                r_clr_addr <= r_clr_addr + 1'b1;
            end
        end
    end

    assign o_valid = r_valid;
    assign o_rsp   = r_rsp;

endmodule

// ===== src/transposition_table_engine_core.sv =====
`timescale 1ns / 1ps
// Channel   Ports                     Handshake
// request   i_req (t_req)             accepted when start && !busy
// result    o_rsp (t_rsp)             valid for one cycle while o_valid is high
//
// Each request passes through table read, evaluate and write back, and the
// result register before its result strobe; the single-ported table sets this.
// A new request can be accepted in the cycle the previous result is shown.
// After reset all 2**INDEX_BITS table entries are swept to zero, one entry per
// cycle, with busy high. The result side cannot stall.

module transposition_table_engine_core
    import tte_pkg::*;
#(
    parameter int INDEX_BITS = 16
)
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic start,
    output logic busy,
    input  t_req i_req,
    output logic o_valid,
    output t_rsp o_rsp
);

    t_ctl ctl;
    t_sts sts;

    tte_ctrl u_ctrl (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .start   (start),
        .busy    (busy),
        .i_sts   (sts),
        .o_ctl   (ctl)
    );

    tte_dp #(
        .INDEX_BITS (INDEX_BITS)
    ) u_dp (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_ctl   (ctl),
        .o_sts   (sts),
        .i_req   (i_req),
        .o_valid (o_valid),
        .o_rsp   (o_rsp)
    );

endmodule

// ===== test/testbench.sv =====
`timescale 1ns / 1ps

module testbench;
    import tte_pkg::*;

    localparam int SLOT_BITS = 16;
    localparam logic [1:0] KIND_UNUSED = 2'd3;
    localparam logic [1:0] BOUND_NONE  = 2'd0;

    class tt_scoreboard;
        t_entry slot_mem [bit [SLOT_BITS-1:0]];
        t_rsp   expected_q[$];
        int     errors = 0;

        function void note_request(t_req r);
            t_entry e;
            t_rsp   x;
            bit [SLOT_BITS-1:0] idx;
            idx = r.hash_key[SLOT_BITS-1:0];
            e = slot_mem.exists(idx) ? slot_mem[idx] : '0;
            x = '0;
            case (r.kind)
                KIND_STORE: begin
                    if (e.key == '0)
                        x.store_outcome = OUTCOME_FILL;
                    else if (e.depth < r.depth)
                        x.store_outcome = OUTCOME_DEEPER;
                    else if (e.age != r.search_age)
                        x.store_outcome = OUTCOME_AGE;
                    else
                        x.store_outcome = OUTCOME_KEPT;
                    if (x.store_outcome != OUTCOME_KEPT)
                        slot_mem[idx] = '{key: r.hash_key, move: r.best_move, score: r.score,
                                          bound: r.bound_kind, depth: r.depth,
                                          age: r.search_age};
                end
                KIND_PROBE, KIND_READ: begin
                    if (e.key == r.hash_key) begin
                        x.found     = 1'b1;
                        x.out_move  = e.move;
                        x.out_bound = e.bound;
                        x.out_depth = e.depth;
                        x.out_age   = e.age;
                        if (r.kind == KIND_READ) begin
                            x.out_score = e.score;
                        end else if (e.key != '0 && e.depth >= r.depth) begin
                            if (e.bound == BOUND_EXACT)
                                x.usable = 1'b1;
                            else if (e.bound == BOUND_UPPER)
                                x.usable = $signed(e.score) <= $signed(r.alpha);
                            else if (e.bound == BOUND_LOWER)
                                x.usable = $signed(e.score) >= $signed(r.beta);
                            if (x.usable)
                                x.out_score = e.score;
                        end
                    end
                end
                default: ;
            endcase
            expected_q.push_back(x);
        endfunction

        function void cmp(string field, logic [15:0] want, logic [15:0] got);
            if (got !== want) begin
                $display("%0t: %s mismatch: expected %h, actual %h", $time, field, want, got);
                errors++;
            end
        endfunction

        function void check_result(t_rsp got);
            t_rsp want;
            if (expected_q.size() == 0) begin
                $display("%0t: unexpected result: expected none, actual %p", $time, got);
                errors++;
                return;
            end
            want = expected_q.pop_front();
            cmp("usable", 16'(want.usable), 16'(got.usable));
            cmp("found", 16'(want.found), 16'(got.found));
            cmp("out_score", want.out_score, got.out_score);
            cmp("out_move", want.out_move, got.out_move);
            cmp("out_bound", 16'(want.out_bound), 16'(got.out_bound));
            cmp("out_depth", 16'(want.out_depth), 16'(got.out_depth));
            cmp("out_age", 16'(want.out_age), 16'(got.out_age));
            cmp("store_outcome", 16'(want.store_outcome), 16'(got.store_outcome));
        endfunction

        function int pending();
            return expected_q.size();
        endfunction
    endclass

    logic i_clk   = 1'b0;
    logic i_rst_n = 1'b0;
    logic start   = 1'b0;
    t_req i_req   = '0;
    logic busy;
    logic o_valid;
    t_rsp o_rsp;

    tt_scoreboard sb = new;

    transposition_table_engine_core #(
        .INDEX_BITS(SLOT_BITS)
    ) uut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .start  (start),
        .busy   (busy),
        .i_req  (i_req),
        .o_valid(o_valid),
        .o_rsp  (o_rsp)
    );

    always #1 i_clk = ~i_clk;

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1)
            sb.check_result(o_rsp);
    end

    function automatic t_req make_req(logic [1:0] kind, logic [63:0] key, logic [15:0] mv,
                                      logic [15:0] sc, logic [1:0] bnd, logic [7:0] dep,
                                      logic [7:0] age, logic [15:0] lo, logic [15:0] hi);
        t_req r;
        r = '{kind: kind, hash_key: key, best_move: mv, score: sc, bound_kind: bnd,
              depth: dep, search_age: age, alpha: lo, beta: hi};
        return r;
    endfunction

    task automatic push_request(input t_req r);
        start <= 1'b1;
        i_req <= r;
        do @(posedge i_clk); while (busy);
        sb.note_request(r);
    endtask

    task automatic idle_for(input int n);
        start <= 1'b0;
        repeat (n) @(posedge i_clk);
    endtask

    task automatic wait_drained();
        start <= 1'b0;
        while (sb.pending() != 0) @(posedge i_clk);
    endtask

    initial begin
        t_req        r;
        logic [63:0] kb;
        logic [63:0] kc;
        logic [47:0] high_pool [4];
        logic [15:0] slot_pool [8];
        logic [15:0] slot;
        logic [7:0]  cur_age;
        int          sel;

        kb = 64'hFFFF_FFFF_FFFF_FFFF;
        kc = 64'h0123_4567_89AB_FFFF;
        cur_age = '0;
        repeat (12) @(posedge i_clk);
        i_rst_n <= 1'b1;

        push_request(make_req(KIND_READ, kb, '0, '0, '0, '0, '0, '0, '0));
        push_request(make_req(KIND_READ, '0, '0, '0, '0, '0, '0, '0, '0));
        push_request(make_req(KIND_PROBE, '0, '0, '0, '0, '0, '0, '0, '0));
        push_request(make_req(KIND_STORE, '0, 16'hFFFF, 16'h8000, BOUND_EXACT, 8'hFF, 8'hFF,
                              '0, '0));
        push_request(make_req(KIND_READ, '0, '0, '0, '0, '0, '0, '0, '0));
        push_request(make_req(KIND_PROBE, '0, '0, '0, '0, '0, '0, 16'h7FFF, 16'h8000));
        push_request(make_req(KIND_STORE, 64'hA5A5_0000_0000_0000, 16'h1234, 16'd100,
                              BOUND_UPPER, '0, '0, '0, '0));
        push_request(make_req(KIND_PROBE, 64'hA5A5_0000_0000_0000, '0, '0, '0, '0, '0,
                              16'd100, '0));
        push_request(make_req(KIND_PROBE, 64'hA5A5_0000_0000_0000, '0, '0, '0, '0, '0,
                              16'd99, '0));
        push_request(make_req(KIND_STORE, kb, 16'hFFFF, 16'h7FFF, BOUND_LOWER, 8'd10, 8'd7,
                              '0, '0));
        push_request(make_req(KIND_PROBE, kb, '0, '0, '0, 8'd10, '0, '0, 16'h7FFF));
        push_request(make_req(KIND_PROBE, kb, '0, '0, '0, 8'd11, '0, '0, 16'h8000));
        push_request(make_req(KIND_PROBE, kb, '0, '0, '0, '0, '0, 16'h7FFF, 16'h8000));
        push_request(make_req(KIND_STORE, kc, 16'h00AA, 16'd1, BOUND_EXACT, 8'd10, 8'd7,
                              '0, '0));
        push_request(make_req(KIND_STORE, kc, 16'h00AA, -16'sd5, BOUND_EXACT, 8'd11, 8'd7,
                              '0, '0));
        push_request(make_req(KIND_STORE, kb, 16'h5555, '0, BOUND_NONE, '0, 8'd8, '0, '0));
        push_request(make_req(KIND_PROBE, kb, '0, '0, '0, '0, '0, 16'h7FFF, 16'h8000));
        push_request(make_req(KIND_PROBE, kc, '0, '0, '0, '0, '0, '0, '0));
        push_request(make_req(KIND_READ, kb, '0, '0, '0, '0, '0, '0, '0));
        push_request(make_req(KIND_UNUSED, kb, 16'hFFFF, 16'hFFFF, 2'd3, 8'hFF, 8'hFF,
                              16'hFFFF, 16'hFFFF));
        push_request(make_req(KIND_STORE, 64'h8000_0000_0000_0002, 16'h0F0F, 16'h8000,
                              BOUND_EXACT, 8'd5, '0, '0, '0));
        push_request(make_req(KIND_PROBE, 64'h8000_0000_0000_0002, '0, '0, '0, 8'd5, '0,
                              16'h8000, 16'h7FFF));
        push_request(make_req(KIND_STORE, 64'h3, '0, -16'sd1, BOUND_LOWER, 8'd1, '0, '0, '0));
        push_request(make_req(KIND_PROBE, 64'h3, '0, '0, '0, 8'd1, '0, '0, '0));

        foreach (high_pool[j])
            high_pool[j] = 48'({$urandom, $urandom});
        high_pool[0] = '0;
        slot_pool = '{16'h0000, 16'hFFFF, 16'h5555, 16'hAAAA, 16'h0001, 16'h8000,
                      16'($urandom), 16'($urandom)};

        for (int i = 0; i < 500; i++) begin
            if (i % 60 == 0)
                cur_age = 8'($urandom);
            slot = ($urandom_range(0, 9) == 0) ? 16'($urandom)
                                               : slot_pool[3'($urandom_range(0, 7))];
            sel = $urandom_range(0, 19);
            if (sel == 0)
                r.hash_key = {$urandom, $urandom};
            else if (sel == 1)
                r.hash_key = '0;
            else
                r.hash_key = {high_pool[2'($urandom_range(0, 3))], slot};
            sel = $urandom_range(0, 19);
            if (sel < 8)
                r.kind = KIND_STORE;
            else if (sel < 15)
                r.kind = KIND_PROBE;
            else if (sel < 19)
                r.kind = KIND_READ;
            else
                r.kind = KIND_UNUSED;
            r.best_move  = 16'($urandom);
            r.score      = 16'($urandom);
            r.bound_kind = 2'($urandom);
            r.depth      = ($urandom_range(0, 7) == 0) ? 8'($urandom) : 8'($urandom_range(0, 12));
            r.search_age = ($urandom_range(0, 9) == 0) ? 8'($urandom) : cur_age;
            r.alpha      = 16'($urandom);
            r.beta       = 16'($urandom);
            push_request(r);
            if (i == 250)
                wait_drained();
            else if (i < 400 && $urandom_range(0, 3) == 0)
                idle_for($urandom_range(1, 8));
        end

        wait_drained();
        repeat (8) @(posedge i_clk);
        if (sb.errors == 0 && sb.pending() == 0)
            $display("Regression PASS");
        else
            $display("Regression FAIL");
        $finish;
    end

    initial begin
        #1_000_000;
        $display("Regression FAIL");
        $finish;
    end

endmodule

// ===== sim.f =====
src/tte_pkg.sv
src/tte_ctrl.sv
src/tte_dp.sv
src/transposition_table_engine_core.sv
test/testbench.sv
